/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the coverage gap scanner checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked at every rising edge outside of reset.
`define CGS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A value must keep its contents in the cycle after a condition holds.
`define CGS_ASSERT_HOLD(label, clk, rst, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

/* src/cgs_pkg.sv */
// ----------------------------------------------------------------------------
// Coverage gap scanner package
// Widths, result kinds, transaction types and the back-end state encoding.
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int POS_BITS   = 32;
  localparam int POS_W      = POS_BITS + 1;
  localparam int LAST_W     = POS_BITS + 2;
  localparam int TALLY_W    = 32;
  localparam int MIN_GAP_W  = 32;
  localparam int CMP_W      = (LAST_W > MIN_GAP_W) ? LAST_W : MIN_GAP_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_CW     = $clog2(POS_W + 1);

  localparam logic [POS_W-1:0] POS_MAX = {1'b1, {POS_BITS{1'b0}}};

  localparam logic RK_GAP = 1'b0;
  localparam logic RK_SUM = 1'b1;

  typedef struct packed {
    logic covered;
    logic seq_end;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [POS_W-1:0] gap_start;
    logic [POS_W-1:0] gap_end;
    logic [POS_W-1:0] covered_count;
    logic [POS_W-1:0] seq_length;
    logic [POS_W-1:0] max_gap;
    logic [POS_W-1:0] avg_gap;
    logic             final_res;
  } out_item_t;

  typedef struct packed {
    logic               has_gap;
    logic               has_sum;
    logic [POS_W-1:0]   gap_start;
    logic [POS_W-1:0]   gap_end;
    logic [POS_W-1:0]   covered_count;
    logic [POS_W-1:0]   seq_length;
    logic [POS_W-1:0]   max_gap;
    logic [POS_W-1:0]   gap_sum;
    logic [TALLY_W-1:0] gap_tally;
  } fe_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GAP,
    BK_DIV,
    BK_SUM
  } bk_state_t;

endpackage

/* src/coverage_gap_scanner_top.sv */
// A gap interval passes through the queue, the back-end work register and the
// result register; a sequence summary also passes through the divider.
// Throughput: 1 input per cycle while the 4-entry queue has room; the back end
// takes one queued transaction at a time and runs the divider for each summary.
// Reset: rst is synchronous; state clears at once and min_gap returns to 1.
// ----------------------------------------------------------------------------
// Coverage gap scanner top level
// Front end, transaction queue and back end of the run-length gap detector.
// ----------------------------------------------------------------------------
module coverage_gap_scanner_top import cgs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             item,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            result,
  input  logic                 min_gap_we,
  input  logic [MIN_GAP_W-1:0] min_gap
);

  fe_entry_t ent;
  fe_entry_t head;
  logic      ent_push;
  logic      fifo_full;
  logic      fifo_empty;
  logic      fifo_pop;

  cgs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .min_gap_we (min_gap_we),
    .min_gap    (min_gap),
    .fifo_full  (fifo_full),
    .ent_push   (ent_push),
    .ent        (ent)
  );

  cgs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (ent_push),
    .wr_data    (ent),
    .rd_en      (fifo_pop),
    .rd_data    (head),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty)
  );

  cgs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .fifo_empty (fifo_empty),
    .fifo_pop   (fifo_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

/* src/cgs_fifo.sv */
// ----------------------------------------------------------------------------
// Coverage gap scanner queue
// Small register queue that decouples the scanning front end from the back end.
// ----------------------------------------------------------------------------
module cgs_fifo import cgs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  fe_entry_t wr_data,
  input  logic      rd_en,
  output fe_entry_t rd_data,
  output logic      fifo_full,
  output logic      fifo_empty
);

  fe_entry_t            store [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 do_wr;
  logic                 do_rd;

  assign fifo_full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign fifo_empty = (count == '0);
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;
  assign rd_data    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + FIFO_CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

/* src/cgs_div.sv */
// ----------------------------------------------------------------------------
// Coverage gap scanner divider
// Restoring divider that retires one quotient bit per cycle for the mean gap.
// ----------------------------------------------------------------------------
module cgs_div import cgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [POS_W-1:0]   dividend,
  input  logic [TALLY_W-1:0] divisor,
  output logic               done,
  output logic [POS_W-1:0]   quotient
);

  logic [DIV_CW-1:0]  cnt;
  logic [POS_W-1:0]   quo;
  logic [TALLY_W-1:0] rem;
  logic [TALLY_W-1:0] dvs;
  logic [TALLY_W:0]   trial;
  logic [TALLY_W:0]   diff;
  logic               ge;
  logic [TALLY_W-1:0] rem_next;

  assign trial    = {rem, quo[POS_W-1]};
  assign ge       = (trial >= {1'b0, dvs});
  assign diff     = trial - {1'b0, dvs};
  assign rem_next = ge ? diff[TALLY_W-1:0] : trial[TALLY_W-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_CW'(POS_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - DIV_CW'(1);
      done <= (cnt == DIV_CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[POS_W-2:0], ge};
      rem <= rem_next;
    end
  end

endmodule

/* src/cgs_front.sv */
// ----------------------------------------------------------------------------
// Coverage gap scanner front end
// Scans one coverage bit per cycle when not full, keeps the run statistics and
// queues the gap intervals and sequence summaries that each bit produces.
// ----------------------------------------------------------------------------
module cgs_front import cgs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  in_item_t             item,
  output logic                 full,
  input  logic                 min_gap_we,
  input  logic [MIN_GAP_W-1:0] min_gap,
  input  logic                 fifo_full,
  output logic                 ent_push,
  output fe_entry_t            ent
);

  logic [MIN_GAP_W-1:0] min_gap_r;
  logic [POS_W-1:0]     pos;
  logic [LAST_W-1:0]    start;
  logic [LAST_W-1:0]    run;
  logic [LAST_W-1:0]    span;
  logic [LAST_W-1:0]    span_p1;
  logic [POS_W-1:0]     cover_total;
  logic [POS_W-1:0]     longest;
  logic [POS_W-1:0]     gsum;
  logic [TALLY_W-1:0]   tally;

  logic [POS_W-1:0]     pos_next;
  logic [LAST_W-1:0]    start_next;
  logic [LAST_W-1:0]    run_next;
  logic [LAST_W-1:0]    span_next;
  logic [LAST_W-1:0]    span_p1_next;
  logic [POS_W-1:0]     cover_total_next;
  logic [POS_W-1:0]     longest_next;
  logic [POS_W-1:0]     gsum_next;
  logic [TALLY_W-1:0]   tally_next;

  logic                 acc;
  logic                 sat;
  logic                 check;
  logic                 note;
  logic                 emit;
  logic [LAST_W-1:0]    d_eff;
  logic [LAST_W-1:0]    g_eff;
  logic [POS_W-1:0]     gap_end;
  logic [LAST_W:0]      sum_wide;

  assign full = fifo_full;
  assign acc  = push && !fifo_full;
  assign sat  = pos[POS_W-1];

  always_comb begin
    pos_next = sat ? pos : pos + POS_W'(1);

    if (item.covered) begin
      d_eff   = span;
      g_eff   = run;
      gap_end = pos;
    end else begin
      d_eff   = sat ? span : span_p1;
      g_eff   = sat ? run : span;
      gap_end = pos_next;
    end

    check = item.covered || item.seq_end;
    note  = check && (|d_eff[LAST_W-1:1]);
    emit  = check && (CMP_W'(d_eff) > CMP_W'(min_gap_r));

    longest_next = longest;
    if (note && (g_eff > LAST_W'(longest))) begin
      longest_next = g_eff[POS_W-1:0];
    end

    sum_wide  = (LAST_W + 1)'(gsum) + (LAST_W + 1)'(g_eff);
    gsum_next = gsum;
    if (note) begin
      gsum_next = (sum_wide > (LAST_W + 1)'(POS_MAX)) ? POS_MAX : sum_wide[POS_W-1:0];
    end

    tally_next = (note && !(&tally)) ? tally + TALLY_W'(1) : tally;

    cover_total_next = (item.covered && !cover_total[POS_W-1]) ?
                       cover_total + POS_W'(1) : cover_total;

    if (item.covered) begin
      start_next   = LAST_W'(pos) + LAST_W'(1);
      run_next     = sat ? '1 : '0;
      span_next    = sat ? LAST_W'(0) : LAST_W'(1);
      span_p1_next = sat ? LAST_W'(1) : LAST_W'(2);
    end else begin
      start_next   = start;
      run_next     = sat ? run : run + LAST_W'(1);
      span_next    = sat ? span : span_p1;
      span_p1_next = sat ? span_p1 : span_p1 + LAST_W'(1);
    end
  end

  always_comb begin
    ent_push          = acc && (emit || item.seq_end);
    ent.has_gap       = emit;
    ent.has_sum       = item.seq_end;
    ent.gap_start     = start[POS_W-1:0];
    ent.gap_end       = gap_end;
    ent.covered_count = cover_total_next;
    ent.seq_length    = pos_next;
    ent.max_gap       = longest_next;
    ent.gap_sum       = gsum_next;
    ent.gap_tally     = tally_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_r <= MIN_GAP_W'(1);
    end else if (min_gap_we) begin
      min_gap_r <= min_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && item.seq_end)) begin
      pos         <= '0;
      start       <= '0;
      run         <= '0;
      span        <= LAST_W'(1);
      span_p1     <= LAST_W'(2);
      cover_total <= '0;
      longest     <= '0;
      gsum        <= '0;
      tally       <= '0;
    end else if (acc) begin
      pos         <= pos_next;
      start       <= start_next;
      run         <= run_next;
      span        <= span_next;
      span_p1     <= span_p1_next;
      cover_total <= cover_total_next;
      longest     <= longest_next;
      gsum        <= gsum_next;
      tally       <= tally_next;
    end
  end

endmodule

/* src/cgs_back.sv */
// ----------------------------------------------------------------------------
// Coverage gap scanner back end
// Drains queued transactions, runs the mean-gap division and holds the
// result register that feeds the output queue interface.
// ----------------------------------------------------------------------------
module cgs_back import cgs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  fe_entry_t head,
  input  logic      fifo_empty,
  output logic      fifo_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  bk_state_t        state;
  bk_state_t        state_next;
  fe_entry_t        work;
  out_item_t        res;
  logic             out_valid;
  logic             slot_free;
  logic             go;
  logic             div_start;
  logic             div_done;
  logic             load_gap;
  logic             load_sum;
  logic [POS_W-1:0] quotient;

  cgs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (work.gap_sum),
    .divisor  (work.gap_tally),
    .done     (div_done),
    .quotient (quotient)
  );

  assign slot_free = !out_valid || pop;
  assign go        = !work.has_gap || slot_free;
  assign empty     = !out_valid;
  assign result    = res;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!fifo_empty) begin
          state_next = BK_GAP;
        end
      end
      BK_GAP: begin
        if (go) begin
          state_next = work.has_sum ? BK_DIV : BK_IDLE;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_SUM;
        end
      end
      BK_SUM: begin
        if (slot_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    fifo_pop  = 1'b0;
    div_start = 1'b0;
    load_gap  = 1'b0;
    load_sum  = 1'b0;
    unique case (state)
      BK_IDLE: fifo_pop = !fifo_empty;
      BK_GAP: begin
        load_gap  = go && work.has_gap;
        div_start = go && work.has_sum;
      end
      BK_DIV: ;
      BK_SUM: load_sum = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_gap || load_sum) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      work <= head;
    end
    if (load_gap) begin
      res.result_kind   <= RK_GAP;
      res.gap_start     <= work.gap_start;
      res.gap_end       <= work.gap_end;
      res.covered_count <= '0;
      res.seq_length    <= '0;
      res.max_gap       <= '0;
      res.avg_gap       <= '0;
      res.final_res     <= !work.has_sum;
    end else if (load_sum) begin
      res.result_kind   <= RK_SUM;
      res.gap_start     <= '0;
      res.gap_end       <= '0;
      res.covered_count <= work.covered_count;
      res.seq_length    <= work.seq_length;
      res.max_gap       <= work.max_gap;
      res.avg_gap       <= (work.gap_tally == '0) ? '0 : quotient;
      res.final_res     <= 1'b1;
    end
  end

endmodule

/* src/cgs_checker.sv */
// ----------------------------------------------------------------------------
// Coverage gap scanner checker
// Port-level assertions on the result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cgs_checker import cgs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  `CGS_ASSERT(a_sum_final, clk, rst, (!empty && result.result_kind == RK_SUM) |-> result.final_res, "summary without final flag")
  `CGS_ASSERT(a_gap_order, clk, rst, (!empty && result.result_kind == RK_GAP) |-> (result.gap_start <= result.gap_end), "gap interval reversed")
  `CGS_ASSERT(a_sum_bounds, clk, rst, (!empty && result.result_kind == RK_SUM) |-> (result.covered_count <= result.seq_length && result.max_gap <= result.seq_length), "summary exceeds length")
  `CGS_ASSERT(a_hold_valid, clk, rst, (!empty && !pop) |=> !empty, "result dropped while stalled")
  `CGS_ASSERT_HOLD(a_hold_data, clk, rst, !empty && !pop, result, "result changed while stalled")

endmodule

bind coverage_gap_scanner_top cgs_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
